### rtl/core/d8fd_pkg.sv
`timescale 1ns / 1ps

package d8fd_pkg;

  // Default elevation width; the top level can override it.
  localparam int unsigned ELEV_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned NUM_NEIGH = 8;
  localparam int unsigned DIR_W     = 4;
  localparam int unsigned EDGE_W    = 4;
  localparam int unsigned NVALID_W  = 8;

  // Result tdata is the direction padded out to one byte.
  localparam int unsigned OUT_TDATA_W = 8;

  // Special direction codes.
  localparam logic [DIR_W-1:0] PIT_CODE  = 4'd0;
  localparam logic [DIR_W-1:0] FLAT_CODE = 4'd10;

endpackage

### rtl/core/d8fd_reduce.sv
`timescale 1ns / 1ps

module d8fd_reduce #(
  parameter int unsigned ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF,
  parameter int unsigned NUM_OUT   = 4
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [2*NUM_OUT-1:0]                          cand_v_i,
  input  logic [2*NUM_OUT-1:0][ELEV_BITS-1:0]           cand_e_i,
  input  logic [2*NUM_OUT-1:0][d8fd_pkg::DIR_W-1:0]     cand_d_i,
  input  logic [ELEV_BITS-1:0]                          centre_i,
  input  logic [d8fd_pkg::EDGE_W-1:0]                   edge_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [NUM_OUT-1:0]                            cand_v_o,
  output logic [NUM_OUT-1:0][ELEV_BITS-1:0]             cand_e_o,
  output logic [NUM_OUT-1:0][d8fd_pkg::DIR_W-1:0]       cand_d_o,
  output logic [ELEV_BITS-1:0]                          centre_o,
  output logic [d8fd_pkg::EDGE_W-1:0]                   edge_o
);

  logic                                      valid_q, valid_d;
  logic                                      load;
  logic [NUM_OUT-1:0]                        v_d, v_q;
  logic [NUM_OUT-1:0][ELEV_BITS-1:0]         e_d, e_q;
  logic [NUM_OUT-1:0][d8fd_pkg::DIR_W-1:0]   dir_d, dir_q;
  logic [ELEV_BITS-1:0]                      centre_q;
  logic [d8fd_pkg::EDGE_W-1:0]               edge_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  // Each pair holds a lower-numbered candidate first, so the first one keeps ties.
  always_comb begin
    for (int i = 0; i < int'(NUM_OUT); i++) begin
      if (cand_v_i[2*i+1] && (!cand_v_i[2*i] ||
          ($signed(cand_e_i[2*i+1]) < $signed(cand_e_i[2*i])))) begin
        v_d[i]   = 1'b1;
        e_d[i]   = cand_e_i[2*i+1];
        dir_d[i] = cand_d_i[2*i+1];
      end else begin
        v_d[i]   = cand_v_i[2*i];
        e_d[i]   = cand_e_i[2*i];
        dir_d[i] = cand_d_i[2*i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      v_q      <= v_d;
      e_q      <= e_d;
      dir_q    <= dir_d;
      centre_q <= centre_i;
      edge_q   <= edge_i;
    end
  end

  assign out_valid_o = valid_q;
  assign cand_v_o    = v_q;
  assign cand_e_o    = e_q;
  assign cand_d_o    = dir_q;
  assign centre_o    = centre_q;
  assign edge_o      = edge_q;

endmodule

### rtl/core/d8fd_resolve.sv
`timescale 1ns / 1ps

module d8fd_resolve #(
  parameter int unsigned ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          low_v_i,
  input  logic [ELEV_BITS-1:0]          low_e_i,
  input  logic [d8fd_pkg::DIR_W-1:0]    low_d_i,
  input  logic [ELEV_BITS-1:0]          centre_i,
  input  logic [d8fd_pkg::EDGE_W-1:0]   edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [d8fd_pkg::DIR_W-1:0]    flow_dir_o
);

  logic                         valid_q, valid_d;
  logic                         load;
  logic [d8fd_pkg::DIR_W-1:0]   dir_raw;
  logic [d8fd_pkg::DIR_W-1:0]   dir_d, dir_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_comb begin
    if (!low_v_i || ($signed(low_e_i) > $signed(centre_i))) begin
      dir_raw = d8fd_pkg::PIT_CODE;
    end else if (low_e_i == centre_i) begin
      dir_raw = d8fd_pkg::FLAT_CODE;
    end else begin
      dir_raw = low_d_i;
    end
    // Border cells drain off the map instead of ending in a pit or flat.
    if ((edge_i != '0) &&
        ((dir_raw == d8fd_pkg::PIT_CODE) || (dir_raw == d8fd_pkg::FLAT_CODE))) begin
      dir_d = edge_i;
    end else begin
      dir_d = dir_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dir_q <= dir_d;
    end
  end

  assign out_valid_o = valid_q;
  assign flow_dir_o  = dir_q;

endmodule

### rtl/core/d8_flow_direction.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata fields, lowest bit first
// s_axis    in         center_elev, elev_n1 .. elev_n8, neighbor_valid, edge_dir, zero pad
// m_axis    out        flow_dir, zero pad
//
// One window is accepted per clock while m_axis is not stalled; its direction passes
// through the three comparison stages of the minimum tree and then the resolve stage,
// which is also the output register.
// Reset (rst_ni low, asynchronous) empties every stage; no beat is in flight afterwards.
// Each stage holds its beat while the stage after it is full and stalled, so a
// stall on m_axis propagates back to s_axis_tready_o without dropping or repeating beats.

module d8_flow_direction #(
  parameter int unsigned ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // center_elev, elev_n1 .. elev_n8 (ELEV_BITS each), neighbor_valid (8), edge_dir (4), pad
  input  logic [((9*ELEV_BITS + d8fd_pkg::NVALID_W + d8fd_pkg::EDGE_W + 7) / 8) * 8 - 1:0]
                      s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // flow_dir (4), pad
  output logic [d8fd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned NN      = d8fd_pkg::NUM_NEIGH;
  localparam int unsigned DW      = d8fd_pkg::DIR_W;
  localparam int unsigned EW      = d8fd_pkg::EDGE_W;
  localparam int unsigned VAL_LSB = 9 * ELEV_BITS;
  localparam int unsigned EDG_LSB = VAL_LSB + d8fd_pkg::NVALID_W;

  // Unpacked input window.
  logic [NN-1:0]                 in_v;
  logic [NN-1:0][ELEV_BITS-1:0]  in_e;
  logic [NN-1:0][DW-1:0]         in_d;
  logic [ELEV_BITS-1:0]          in_centre;
  logic [EW-1:0]                 in_edge;

  assign in_centre = s_axis_tdata_i[ELEV_BITS-1:0];
  assign in_v      = s_axis_tdata_i[VAL_LSB +: d8fd_pkg::NVALID_W];
  assign in_edge   = s_axis_tdata_i[EDG_LSB +: EW];

  // Neighbour k (1 to 8) sits in slot k-1 and carries its own direction code.
  for (genvar k = 0; k < NN; k++) begin : g_unpack
    assign in_e[k] = s_axis_tdata_i[(k+1)*ELEV_BITS +: ELEV_BITS];
    assign in_d[k] = DW'(k + 1);
  end

  // Stage 1: eight candidates to four.
  logic                          s1_valid, s1_ready;
  logic [3:0]                    s1_v;
  logic [3:0][ELEV_BITS-1:0]     s1_e;
  logic [3:0][DW-1:0]            s1_d;
  logic [ELEV_BITS-1:0]          s1_centre;
  logic [EW-1:0]                 s1_edge;

  d8fd_reduce #(.ELEV_BITS(ELEV_BITS), .NUM_OUT(4)) u_stage1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cand_v_i   (in_v),
    .cand_e_i   (in_e),
    .cand_d_i   (in_d),
    .centre_i   (in_centre),
    .edge_i     (in_edge),
    .out_valid_o(s1_valid),
    .out_ready_i(s1_ready),
    .cand_v_o   (s1_v),
    .cand_e_o   (s1_e),
    .cand_d_o   (s1_d),
    .centre_o   (s1_centre),
    .edge_o     (s1_edge)
  );

  // Stage 2: four to two.
  logic                          s2_valid, s2_ready;
  logic [1:0]                    s2_v;
  logic [1:0][ELEV_BITS-1:0]     s2_e;
  logic [1:0][DW-1:0]            s2_d;
  logic [ELEV_BITS-1:0]          s2_centre;
  logic [EW-1:0]                 s2_edge;

  d8fd_reduce #(.ELEV_BITS(ELEV_BITS), .NUM_OUT(2)) u_stage2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid),
    .in_ready_o (s1_ready),
    .cand_v_i   (s1_v),
    .cand_e_i   (s1_e),
    .cand_d_i   (s1_d),
    .centre_i   (s1_centre),
    .edge_i     (s1_edge),
    .out_valid_o(s2_valid),
    .out_ready_i(s2_ready),
    .cand_v_o   (s2_v),
    .cand_e_o   (s2_e),
    .cand_d_o   (s2_d),
    .centre_o   (s2_centre),
    .edge_o     (s2_edge)
  );

  // Stage 3: two to the single lowest neighbour.
  logic                          s3_valid, s3_ready;
  logic [0:0]                    s3_v;
  logic [0:0][ELEV_BITS-1:0]     s3_e;
  logic [0:0][DW-1:0]            s3_d;
  logic [ELEV_BITS-1:0]          s3_centre;
  logic [EW-1:0]                 s3_edge;

  d8fd_reduce #(.ELEV_BITS(ELEV_BITS), .NUM_OUT(1)) u_stage3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s2_valid),
    .in_ready_o (s2_ready),
    .cand_v_i   (s2_v),
    .cand_e_i   (s2_e),
    .cand_d_i   (s2_d),
    .centre_i   (s2_centre),
    .edge_i     (s2_edge),
    .out_valid_o(s3_valid),
    .out_ready_i(s3_ready),
    .cand_v_o   (s3_v),
    .cand_e_o   (s3_e),
    .cand_d_o   (s3_d),
    .centre_o   (s3_centre),
    .edge_o     (s3_edge)
  );

  // Stage 4: compare with the centre, apply the border rule, register the result.
  logic [DW-1:0] flow_dir;

  d8fd_resolve #(.ELEV_BITS(ELEV_BITS)) u_resolve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s3_valid),
    .in_ready_o (s3_ready),
    .low_v_i    (s3_v[0]),
    .low_e_i    (s3_e[0]),
    .low_d_i    (s3_d[0]),
    .centre_i   (s3_centre),
    .edge_i     (s3_edge),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .flow_dir_o (flow_dir)
  );

  assign m_axis_tdata_o = {{(d8fd_pkg::OUT_TDATA_W - DW){1'b0}}, flow_dir};

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ELEV_W      = d8fd_pkg::ELEV_BITS_DEF;
  localparam int unsigned NVALID_W    = d8fd_pkg::NVALID_W;
  localparam int unsigned EDGE_W      = d8fd_pkg::EDGE_W;
  localparam int unsigned DIR_W       = d8fd_pkg::DIR_W;
  localparam int unsigned OUT_TDATA_W = d8fd_pkg::OUT_TDATA_W;
  localparam int unsigned TDATA_W = ((9 * ELEV_W + NVALID_W + EDGE_W + 7) / 8) * 8;

  localparam logic [DIR_W-1:0] PIT_CODE  = d8fd_pkg::PIT_CODE;
  localparam logic [DIR_W-1:0] FLAT_CODE = d8fd_pkg::FLAT_CODE;

  localparam logic [ELEV_W-1:0] E_LO = 16'h8000;
  localparam logic [ELEV_W-1:0] E_HI = 16'h7FFF;

  // One 3x3 window. The neighbours are indexed 1 (north) to 8 (north-west).
  typedef struct packed {
    logic [ELEV_W-1:0]      centre;
    logic [1:8][ELEV_W-1:0] neigh;
    logic [NVALID_W-1:0]    nvalid;
    logic [EDGE_W-1:0]      edge_dir;
  } window_t;

  // A directed row carries its answer only when it is obvious by inspection.
  typedef struct packed {
    window_t          win;
    logic             known;
    logic [DIR_W-1:0] dir;
  } dir_row_t;

  localparam int N_DIRECTED = 20;

  localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // No neighbour inside the raster: a pit, or the border direction.
    '{'{16'sd0, '{8{16'sd0}}, 8'h00, 4'd0}, 1'b1, PIT_CODE},
    '{'{16'sd0, '{8{16'sd0}}, 8'h00, 4'd3}, 1'b1, 4'd3},
    // Everything level: flat, or the border direction on the edge.
    '{'{16'sd5, '{8{16'sd5}}, 8'hFF, 4'd0}, 1'b1, FLAT_CODE},
    '{'{16'sd5, '{8{16'sd5}}, 8'hFF, 4'd7}, 1'b1, 4'd7},
    // Elevation extremes.
    '{'{E_LO, '{8{E_HI}}, 8'hFF, 4'd0}, 1'b1, PIT_CODE},
    '{'{E_HI, '{8{E_LO}}, 8'hFF, 4'd0}, 1'b1, 4'd1},
    '{'{E_HI, '{8{E_LO}}, 8'h80, 4'd0}, 1'b1, 4'd8},
    '{'{E_LO, '{8{E_LO}}, 8'hFF, 4'd0}, 1'b1, FLAT_CODE},
    // Signed comparison around zero.
    '{'{16'sd0, '{16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        8'h01, 4'd0}, 1'b1, 4'd1},
    '{'{16'hFFFF, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        8'h01, 4'd0}, 1'b1, PIT_CODE},
    // Out-of-range border codes are passed through as they stand.
    '{'{16'sd0, '{8{16'sd0}}, 8'hFF, 4'd9}, 1'b1, 4'd9},
    '{'{16'sd0, '{8{16'sd1}}, 8'hFF, 4'd10}, 1'b1, 4'd10},
    '{'{16'sd0, '{8{16'sd1}}, 8'hFF, 4'd15}, 1'b1, 4'd15},
    // Ties, masked-out minima and real downslopes on border cells.
    '{'{16'sd100, '{16'sd50, 16'sd40, 16'sd20, 16'sd60, 16'sd70, 16'sd20, 16'sd90, 16'sd80},
        8'hFF, 4'd0}, 1'b0, PIT_CODE},
    '{'{16'sd100, '{16'sd50, 16'sd40, 16'sd20, 16'sd60, 16'sd70, 16'sd20, 16'sd90, 16'sd80},
        8'hFB, 4'd0}, 1'b0, PIT_CODE},
    '{'{16'sd100, '{16'sd99, 16'sd10, 16'sd120, 16'sd101, 16'sd99, 16'sd130, 16'sd140,
        16'sd150}, 8'hFD, 4'd0}, 1'b0, PIT_CODE},
    '{'{16'sd0, '{16'sd5, 16'sd5, 16'sd5, 16'sd5, -16'sd3, 16'sd5, 16'sd5, 16'sd5},
        8'hFF, 4'd4}, 1'b0, PIT_CODE},
    '{'{-16'sd10, '{-16'sd9, -16'sd9, -16'sd9, -16'sd9, -16'sd9, -16'sd9, -16'sd11, -16'sd9},
        8'hFF, 4'd8}, 1'b0, PIT_CODE},
    '{'{E_HI, '{E_HI, E_HI, E_HI, 16'h7FFE, E_HI, E_HI, E_HI, E_HI}, 8'hFF, 4'd0},
        1'b0, PIT_CODE},
    '{'{16'sd0, '{8{E_HI}}, 8'hAA, 4'd2}, 1'b1, 4'd2}
  };

  // Idling per phase, in percent: none, sender, receiver, both lightly.
  localparam int N_PHASES = 4;
  localparam int SRC_IDLE [0:N_PHASES-1] = '{0, 78, 0, 6};
  localparam int SNK_STALL [0:N_PHASES-1] = '{0, 0, 78, 6};
  localparam int RANDOM_PER_PHASE = 383;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               m_tready = 1'b0;
  logic               s_tready;
  logic               m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int n_fail        = 0;

  // Directions still owed by the block, oldest first.
  logic [DIR_W-1:0] flow_dir_q [$];

  d8_flow_direction u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Lowest valid neighbour, first one wins a tie; pit and flat give way to
  // the border direction on edge cells.
  function automatic logic [DIR_W-1:0] d8_direction(input window_t w);
    logic                     found;
    logic signed [ELEV_W-1:0] lowest;
    logic [DIR_W-1:0]         dir;
    found  = 1'b0;
    lowest = '0;
    dir    = PIT_CODE;
    for (int k = 1; k <= 8; k++) begin
      if (w.nvalid[k-1] && (!found || $signed(w.neigh[k]) < lowest)) begin
        found  = 1'b1;
        lowest = $signed(w.neigh[k]);
        dir    = DIR_W'(k);
      end
    end
    if (!found || lowest > $signed(w.centre)) begin
      dir = PIT_CODE;
    end else if (lowest == $signed(w.centre)) begin
      dir = FLAT_CODE;
    end
    if (w.edge_dir != '0 && (dir == PIT_CODE || dir == FLAT_CODE)) begin
      dir = w.edge_dir;
    end
    return dir;
  endfunction

  // Most windows cluster around one height so that ties, flats and pits are
  // common; the rest are fully random.
  function automatic window_t random_window();
    window_t w;
    int      base;
    int      spread;
    case ($urandom_range(7))
      0: base = -32768;
      1: base = 32767;
      default: base = int'($urandom);
    endcase
    spread = $urandom_range(3);
    if ($urandom_range(3) == 0) begin
      w.centre = ELEV_W'($urandom);
      for (int k = 1; k <= 8; k++) w.neigh[k] = ELEV_W'($urandom);
    end else begin
      w.centre = ELEV_W'(base + $urandom_range(2 * spread) - spread);
      for (int k = 1; k <= 8; k++) begin
        w.neigh[k] = ELEV_W'(base + $urandom_range(2 * spread) - spread);
      end
    end
    case ($urandom_range(3))
      0, 1: w.nvalid = 8'hFF;
      2: w.nvalid = 8'($urandom);
      default: w.nvalid = 8'(1 << $urandom_range(8));
    endcase
    case ($urandom_range(9))
      6, 7, 8: w.edge_dir = EDGE_W'($urandom_range(8, 1));
      9: w.edge_dir = EDGE_W'($urandom_range(15, 9));
      default: w.edge_dir = '0;
    endcase
    return w;
  endfunction

  // Called just after a rising edge; returns just after the edge at which
  // the beat was taken, so the next call can drive straight on.
  task automatic send_window(input window_t w, input logic [DIR_W-1:0] dir);
    logic [TDATA_W-1:0] beat;
    beat = '0;
    beat[ELEV_W-1:0] = w.centre;
    for (int k = 1; k <= 8; k++) beat[k*ELEV_W +: ELEV_W] = w.neigh[k];
    beat[9*ELEV_W +: NVALID_W] = w.nvalid;
    beat[9*ELEV_W+NVALID_W +: EDGE_W] = w.edge_dir;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    // Ready is settled by the falling edge; the beat moves at the next rise.
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    flow_dir_q.push_back(dir);
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Result beats are sampled at the falling edge before the rising edge that takes them.
  always @(negedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (flow_dir_q.size() == 0) begin
        $error("flow_dir: no result expected, got %0d", m_tdata[DIR_W-1:0]);
        n_fail++;
      end else begin
        logic [DIR_W-1:0] want_dir;
        want_dir = flow_dir_q.pop_front();
        if (m_tdata[DIR_W-1:0] !== want_dir) begin
          $error("flow_dir: expected %0d, got %0d", want_dir, m_tdata[DIR_W-1:0]);
          n_fail++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    window_t  w;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      send_window(row.win, row.known ? row.dir : d8_direction(row.win));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      src_idle_pct  = SRC_IDLE[p];
      snk_stall_pct = SNK_STALL[p];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        w = random_window();
        send_window(w, d8_direction(w));
      end
    end
    s_tvalid <= 1'b0;

    while (flow_dir_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/d8fd_pkg.sv
rtl/core/d8fd_reduce.sv
rtl/core/d8fd_resolve.sv
rtl/core/d8_flow_direction.sv
verif/tb_top.sv
